[hdl/ccc_pkg.sv]
// shared constants and register indexes for the climate chamber controller
package ccc_pkg;

   localparam int unsigned TEMP_W    = 11;
   localparam int unsigned HUM_W     = 10;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned MIN_W     = 11;
   localparam int unsigned PCT_W     = 7;
   localparam int unsigned MIST_W    = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;
   // minutes times sixty, for an 11 bit minute count
   localparam int unsigned LIM_S_W   = 17;

   localparam logic [TIME_W-1:0] SERVO_HOLD_MS = 32'd10000;
   localparam logic [TIME_W-1:0] MIST_OFF_MS   = 32'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT_TEMP   = 3'd0,
      CSR_EXHAUST_INT_MIN = 3'd1,
      CSR_EXHAUST_OPEN    = 3'd2,
      CSR_DRUM_INT_MIN    = 3'd3,
      CSR_DRUM_ON_MIN     = 3'd4,
      CSR_HUMIDITY_LOW    = 3'd5,
      CSR_HUMIDITY_HIGH   = 3'd6,
      CSR_MIST_ON_MS      = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_BOTH   = 2'd0,
      STATUS_FIRST  = 2'd1,
      STATUS_SECOND = 2'd2,
      STATUS_NONE   = 2'd3
   } sensor_status_type;

endpackage

[hdl/climate_chamber_controller.sv]
// climate chamber controller: sensor fusion, cooler, exhaust, drum, servo and misting
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | time stamps, two sensor readings
//   rsp_    | out       | rsp_valid / rsp_ready | drive outputs, fused readings, status
//   csr_    | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// one transaction per cycle unless the result stalls; a taken request passes through the
// input register, then the result register; the single pass in between sets the rate.
// control state is updated as an item moves into the result register.
// synchronous active-high reset restores the register defaults, clears the control state and both valid flags.
// a stalled result holds the pipe; the input register still fills while it waits, if it is empty.
module climate_chamber_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ccc_pkg::TIME_W-1:0]         req_now_seconds,
   input  logic [ccc_pkg::TIME_W-1:0]         req_now_ms,
   input  logic signed [ccc_pkg::TEMP_W-1:0]  req_temp_a,
   input  logic [ccc_pkg::HUM_W-1:0]          req_hum_a,
   input  logic                               req_ok_a,
   input  logic signed [ccc_pkg::TEMP_W-1:0]  req_temp_b,
   input  logic [ccc_pkg::HUM_W-1:0]          req_hum_b,
   input  logic                               req_ok_b,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_cooler_on,
   output logic                               rsp_pump_on,
   output logic                               rsp_exhaust_open,
   output logic                               rsp_servo_power,
   output logic                               rsp_drum_on,
   output logic signed [ccc_pkg::TEMP_W-1:0]  rsp_avg_temp_out,
   output logic [ccc_pkg::HUM_W-1:0]          rsp_avg_hum_out,
   output logic [1:0]                         rsp_sensor_status,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ccc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ccc_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   // configuration registers
   logic signed [ccc_pkg::TEMP_W-1:0] setpoint_ff;
   logic [ccc_pkg::MIN_W-1:0]         exh_int_ff, exh_open_ff, drum_int_ff, drum_on_min_ff;
   logic [ccc_pkg::PCT_W-1:0]         hum_low_ff, hum_high_ff;
   logic [ccc_pkg::MIST_W-1:0]        mist_on_ff;

   // input register
   logic                              s1_valid_ff;
   logic [ccc_pkg::TIME_W-1:0]        s1_sec_ff, s1_ms_ff;
   logic signed [ccc_pkg::TEMP_W-1:0] s1_ta_ff, s1_tb_ff;
   logic [ccc_pkg::HUM_W-1:0]         s1_ha_ff, s1_hb_ff;
   logic                              s1_oka_ff, s1_okb_ff;

   // control state
   logic signed [ccc_pkg::TEMP_W-1:0] avg_temp_ff, avg_temp_in;
   logic [ccc_pkg::HUM_W-1:0]         avg_hum_ff, avg_hum_in;
   logic                              exh_open_st_ff, exh_open_st_in;
   logic [ccc_pkg::TIME_W-1:0]        exh_mark_ff, exh_mark_in;
   logic                              drum_st_ff, drum_st_in;
   logic [ccc_pkg::TIME_W-1:0]        drum_mark_ff, drum_mark_in;
   logic                              servo_ff, servo_in;
   logic [ccc_pkg::TIME_W-1:0]        servo_ms_ff, servo_ms_in;
   logic                              pump_ff, pump_in;
   logic                              pulse_ff, pulse_in;
   logic [ccc_pkg::TIME_W-1:0]        pump_start_ff, pump_start_in;
   logic [ccc_pkg::TIME_W-1:0]        pump_off_ff, pump_off_in;
   logic                              cooler_in;
   logic [1:0]                        status_in;

   // result register
   logic                              rsp_valid_ff;
   logic                              cooler_ff;
   logic [1:0]                        status_ff;

   logic advance;
   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign req_ready = ~s1_valid_ff | advance;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- fusion
   logic signed [ccc_pkg::TEMP_W:0] t_sum, t_adj;
   logic [ccc_pkg::HUM_W:0]         h_sum;

   always_comb begin
      t_sum = {s1_ta_ff[ccc_pkg::TEMP_W-1], s1_ta_ff} + {s1_tb_ff[ccc_pkg::TEMP_W-1], s1_tb_ff};
      // round toward zero for negative odd sums
      t_adj = t_sum + {{ccc_pkg::TEMP_W{1'b0}}, t_sum[ccc_pkg::TEMP_W]};
      h_sum = {1'b0, s1_ha_ff} + {1'b0, s1_hb_ff};
      avg_temp_in = avg_temp_ff;
      avg_hum_in  = avg_hum_ff;
      status_in   = ccc_pkg::STATUS_NONE;
      if (s1_oka_ff && s1_okb_ff) begin
         avg_temp_in = t_adj[ccc_pkg::TEMP_W:1];
         avg_hum_in  = h_sum[ccc_pkg::HUM_W:1];
         status_in   = ccc_pkg::STATUS_BOTH;
      end else if (s1_oka_ff) begin
         avg_temp_in = s1_ta_ff;
         avg_hum_in  = s1_ha_ff;
         status_in   = ccc_pkg::STATUS_FIRST;
      end else if (s1_okb_ff) begin
         avg_temp_in = s1_tb_ff;
         avg_hum_in  = s1_hb_ff;
         status_in   = ccc_pkg::STATUS_SECOND;
      end
   end

   // ------------------------------------------------------- exhaust, servo, drum
   logic [ccc_pkg::MIN_W-1:0]   exh_lim, drum_lim;
   logic [ccc_pkg::LIM_S_W-1:0] exh_lim_s, drum_lim_s;
   logic [ccc_pkg::TIME_W-1:0]  exh_dt, drum_dt, servo_dt;
   logic                        exh_toggle, drum_toggle;

   always_comb begin
      exh_lim  = exh_open_st_ff ? exh_open_ff : exh_int_ff;
      drum_lim = drum_st_ff ? drum_on_min_ff : drum_int_ff;
      // whole minutes >= limit is the same as seconds >= limit * 60
      exh_lim_s  = ({6'd0, exh_lim} << 6) - ({6'd0, exh_lim} << 2);
      drum_lim_s = ({6'd0, drum_lim} << 6) - ({6'd0, drum_lim} << 2);
      exh_dt     = s1_sec_ff - exh_mark_ff;
      drum_dt    = s1_sec_ff - drum_mark_ff;
      exh_toggle  = exh_dt >= {{(ccc_pkg::TIME_W-ccc_pkg::LIM_S_W){1'b0}}, exh_lim_s};
      drum_toggle = drum_dt >= {{(ccc_pkg::TIME_W-ccc_pkg::LIM_S_W){1'b0}}, drum_lim_s};
      servo_dt    = s1_ms_ff - servo_ms_ff;

      exh_open_st_in = exh_open_st_ff ^ exh_toggle;
      exh_mark_in    = exh_toggle ? s1_sec_ff : exh_mark_ff;
      drum_st_in     = drum_st_ff ^ drum_toggle;
      drum_mark_in   = drum_toggle ? s1_sec_ff : drum_mark_ff;

      // a fresh move cannot expire on the same tick
      servo_in    = servo_ff;
      servo_ms_in = servo_ms_ff;
      if (exh_toggle) begin
         servo_in    = 1'b1;
         servo_ms_in = s1_ms_ff;
      end else if (servo_ff && servo_dt >= ccc_pkg::SERVO_HOLD_MS) begin
         servo_in = 1'b0;
      end
   end

   // --------------------------------------------------------- cooler, misting
   logic [ccc_pkg::TEMP_W-1:0]      low10, high10;
   logic signed [ccc_pkg::TEMP_W:0] stop10;
   logic [ccc_pkg::TIME_W-1:0]      start_dt, off_dt;
   logic                            started, stopped;

   always_comb begin
      cooler_in = avg_temp_in > setpoint_ff;
      low10  = ({4'd0, hum_low_ff} << 3) + ({4'd0, hum_low_ff} << 1);
      high10 = ({4'd0, hum_high_ff} << 3) + ({4'd0, hum_high_ff} << 1);
      stop10 = $signed({1'b0, high10}) - 12'sd10;
      start_dt = s1_ms_ff - pump_start_ff;
      off_dt   = s1_ms_ff - pump_off_ff;

      pump_in       = pump_ff;
      pulse_in      = pulse_ff;
      pump_start_in = pump_start_ff;
      pump_off_in   = pump_off_ff;
      started       = 1'b0;
      stopped       = 1'b0;

      if ({1'b0, avg_hum_in} < low10) begin
         if (!pulse_ff) begin
            if (!pump_ff) begin
               pump_start_in = s1_ms_ff;
               pump_in       = 1'b1;
               started       = 1'b1;
            end
            pulse_in = 1'b1;
         end
         // time since start is zero when the pulse begins on this tick
         if (pump_in && (started ? (ccc_pkg::MIST_W'(0) >= mist_on_ff)
                                 : (start_dt >= {16'd0, mist_on_ff}))) begin
            pump_in     = 1'b0;
            pump_off_in = s1_ms_ff;
            stopped     = 1'b1;
         end
         if (!pump_in && pulse_in && !stopped && off_dt >= ccc_pkg::MIST_OFF_MS) begin
            if ($signed({2'b00, avg_hum_in}) >= stop10)
               pulse_in = 1'b0;
         end
      end else begin
         pulse_in = 1'b0;
         pump_in  = 1'b0;
      end
      if ({1'b0, avg_hum_in} >= high10 && pump_in) begin
         pump_in  = 1'b0;
         pulse_in = 1'b0;
      end
   end

   // ----------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff    <= 11'sd500;
         exh_int_ff     <= 11'd1;
         exh_open_ff    <= 11'd1;
         drum_int_ff    <= 11'd1;
         drum_on_min_ff <= 11'd1;
         hum_low_ff     <= 7'd65;
         hum_high_ff    <= 7'd75;
         mist_on_ff     <= 16'd1000;
      end else if (csr_valid && csr_ready) begin
         unique case (ccc_pkg::csr_index_type'(csr_index))
            ccc_pkg::CSR_SETPOINT_TEMP:   setpoint_ff    <= $signed(csr_wdata[ccc_pkg::TEMP_W-1:0]);
            ccc_pkg::CSR_EXHAUST_INT_MIN: exh_int_ff     <= csr_wdata[ccc_pkg::MIN_W-1:0];
            ccc_pkg::CSR_EXHAUST_OPEN:    exh_open_ff    <= csr_wdata[ccc_pkg::MIN_W-1:0];
            ccc_pkg::CSR_DRUM_INT_MIN:    drum_int_ff    <= csr_wdata[ccc_pkg::MIN_W-1:0];
            ccc_pkg::CSR_DRUM_ON_MIN:     drum_on_min_ff <= csr_wdata[ccc_pkg::MIN_W-1:0];
            ccc_pkg::CSR_HUMIDITY_LOW:    hum_low_ff     <= csr_wdata[ccc_pkg::PCT_W-1:0];
            ccc_pkg::CSR_HUMIDITY_HIGH:   hum_high_ff    <= csr_wdata[ccc_pkg::PCT_W-1:0];
            ccc_pkg::CSR_MIST_ON_MS:      mist_on_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready)
            s1_valid_ff <= req_valid;
         if (advance)
            rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_sec_ff <= req_now_seconds;
         s1_ms_ff  <= req_now_ms;
         s1_ta_ff  <= req_temp_a;
         s1_ha_ff  <= req_hum_a;
         s1_oka_ff <= req_ok_a;
         s1_tb_ff  <= req_temp_b;
         s1_hb_ff  <= req_hum_b;
         s1_okb_ff <= req_ok_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_temp_ff    <= '0;
         avg_hum_ff     <= '0;
         exh_open_st_ff <= 1'b0;
         exh_mark_ff    <= '0;
         drum_st_ff     <= 1'b0;
         drum_mark_ff   <= '0;
         servo_ff       <= 1'b0;
         servo_ms_ff    <= '0;
         pump_ff        <= 1'b0;
         pulse_ff       <= 1'b0;
         pump_start_ff  <= '0;
         pump_off_ff    <= '0;
         cooler_ff      <= 1'b0;
         status_ff      <= '0;
      end else if (s1_valid_ff && advance) begin
         avg_temp_ff    <= avg_temp_in;
         avg_hum_ff     <= avg_hum_in;
         exh_open_st_ff <= exh_open_st_in;
         exh_mark_ff    <= exh_mark_in;
         drum_st_ff     <= drum_st_in;
         drum_mark_ff   <= drum_mark_in;
         servo_ff       <= servo_in;
         servo_ms_ff    <= servo_ms_in;
         pump_ff        <= pump_in;
         pulse_ff       <= pulse_in;
         pump_start_ff  <= pump_start_in;
         pump_off_ff    <= pump_off_in;
         cooler_ff      <= cooler_in;
         status_ff      <= status_in;
      end
   end

   // the state registers double as the result register
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cooler_on     = cooler_ff;
   assign rsp_pump_on       = pump_ff;
   assign rsp_exhaust_open  = exh_open_st_ff;
   assign rsp_servo_power   = servo_ff;
   assign rsp_drum_on       = drum_st_ff;
   assign rsp_avg_temp_out  = avg_temp_ff;
   assign rsp_avg_hum_out   = avg_hum_ff;
   assign rsp_sensor_status = status_ff;

endmodule
